// ----- sv/opl_pkg.sv -----
package opl_pkg;

    // default list depth
    localparam int unsigned CAPACITY = 64;

    // field widths
    localparam int unsigned REQ_W   = 4;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INS_FIRST = 4'd0;
    localparam logic [REQ_W-1:0] REQ_INS_LAST  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 4'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_AT    = 4'd5;
    localparam logic [REQ_W-1:0] REQ_DEL_MATCH = 4'd6;
    localparam logic [REQ_W-1:0] REQ_GET       = 4'd7;
    localparam logic [REQ_W-1:0] REQ_REPLACE   = 4'd8;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // internal operation kinds
    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_RD  = 2'd2;
    localparam logic [1:0] OP_WR  = 2'd3;

endpackage

// ----- sv/opl_if.sv -----
interface opl_req_if;
    logic                                  valid;
    logic                                  ready;
    logic        [opl_pkg::REQ_W-1:0]      req_type;
    logic        [opl_pkg::POS_W-1:0]      position;
    logic signed [opl_pkg::COORD_W-1:0]    point_x;
    logic signed [opl_pkg::COORD_W-1:0]    point_y;

    modport source (output valid, req_type, position, point_x, point_y, input ready);
    modport sink   (input valid, req_type, position, point_x, point_y, output ready);
endinterface

interface opl_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic        [opl_pkg::STAT_W-1:0]     status;
    logic signed [opl_pkg::COORD_W-1:0]    out_x;
    logic signed [opl_pkg::COORD_W-1:0]    out_y;
    logic        [opl_pkg::CNT_W-1:0]      entry_count;

    modport source (output valid, status, out_x, out_y, entry_count, input ready);
    modport sink   (input valid, status, out_x, out_y, entry_count, output ready);
endinterface

// ----- sv/ordered_point_list_engine_unit.sv -----
// Channel   Dir  Fields
// i_req     in   req_type, position, point_x, point_y
// o_rsp     out  status, out_x, out_y, entry_count
//
// One request at a time. An accepted request passes through the work and finish states,
// where the result is registered; a match delete scans from the front. A rejected
// request skips the work state. One memory entry is moved per cycle through the
// single-port-read point memory. The engine is ready for the next request in the
// same cycle that the result appears in the output register.
// Reset clears the count and control only; the memory needs no clearing.
// A result waits in the output register; the engine stalls before finishing
// the next request until that slot is free.
module ordered_point_list_engine_unit #(
    parameter int unsigned CAPACITY = opl_pkg::CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    opl_req_if.sink         i_req,
    opl_rsp_if.source       o_rsp
);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CMPW = (CW > opl_pkg::POS_W) ? CW : opl_pkg::POS_W;
    localparam int unsigned DW   = 2 * opl_pkg::COORD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [DW-1:0] r_mem [CAPACITY];
    logic [DW-1:0] r_rdata;

    logic [1:0]                       r_state;
    logic [CW-1:0]                    r_count;
    logic [1:0]                       r_op;
    logic [opl_pkg::STAT_W-1:0]       r_err;
    logic [AW-1:0]                    r_ptr, r_pa, r_idx;
    logic [CW-1:0]                    r_left;
    logic                             r_any, r_found, r_pv;
    logic [DW-1:0]                    r_pt, r_old;

    logic                             r_ov;
    logic [opl_pkg::STAT_W-1:0]       r_os;
    logic [DW-1:0]                    r_opt;
    logic [opl_pkg::CNT_W-1:0]        r_ocnt;

    // request decode
    logic [CMPW-1:0]            cnt_e, pos_e, idx_e;
    logic [1:0]                 n_op;
    logic [opl_pkg::STAT_W-1:0] n_err;
    logic [AW-1:0]              n_ptr;
    logic [CW-1:0]              n_left;
    logic                       n_any, n_found;

    always_comb begin
        cnt_e   = CMPW'(r_count);
        pos_e   = CMPW'(i_req.position);
        idx_e   = pos_e;
        n_op    = opl_pkg::OP_RD;
        n_err   = opl_pkg::ST_OK;
        n_ptr   = idx_e[AW-1:0];
        n_left  = '0;
        n_any   = 1'b1;
        n_found = 1'b0;
        unique case (i_req.req_type)
            opl_pkg::REQ_INS_FIRST, opl_pkg::REQ_INS_LAST, opl_pkg::REQ_INS_AT: begin
                n_op    = opl_pkg::OP_INS;
                n_found = 1'b1;
                if (i_req.req_type == opl_pkg::REQ_INS_FIRST) idx_e = '0;
                else if (i_req.req_type == opl_pkg::REQ_INS_LAST) idx_e = cnt_e;
                n_ptr  = AW'(cnt_e - CMPW'(1));
                n_left = CW'(cnt_e - idx_e);
                if (r_count == CW'(CAPACITY)) n_err = opl_pkg::ST_FULL;
                else if (idx_e > cnt_e) n_err = opl_pkg::ST_RANGE;
            end
            opl_pkg::REQ_DEL_FIRST, opl_pkg::REQ_DEL_LAST, opl_pkg::REQ_DEL_AT: begin
                n_op = opl_pkg::OP_DEL;
                if (i_req.req_type == opl_pkg::REQ_DEL_FIRST) idx_e = '0;
                else if (i_req.req_type == opl_pkg::REQ_DEL_LAST)
                    idx_e = cnt_e - CMPW'(1);
                n_ptr  = idx_e[AW-1:0];
                n_left = CW'(cnt_e - idx_e);
                if (r_count == '0 || idx_e >= cnt_e) n_err = opl_pkg::ST_RANGE;
            end
            opl_pkg::REQ_DEL_MATCH: begin
                n_op   = opl_pkg::OP_DEL;
                n_ptr  = '0;
                n_left = r_count;
                n_any  = 1'b0;
            end
            opl_pkg::REQ_GET, opl_pkg::REQ_REPLACE: begin
                n_op   = (i_req.req_type == opl_pkg::REQ_GET) ? opl_pkg::OP_RD
                                                              : opl_pkg::OP_WR;
                n_left = CW'(1);
                if (pos_e >= cnt_e) n_err = opl_pkg::ST_RANGE;
            end
            default: n_err = opl_pkg::ST_RANGE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    // finish-stage result
    logic                       fin_go;
    logic [opl_pkg::STAT_W-1:0] fin_st;
    logic [CW-1:0]              fin_cnt;

    always_comb begin
        fin_go  = (r_state == S_FIN) && (!r_ov || o_rsp.ready);
        fin_st  = r_err;
        fin_cnt = r_count;
        if (r_err == opl_pkg::ST_OK) begin
            if (r_op == opl_pkg::OP_INS) fin_cnt = r_count + CW'(1);
            else if (r_op == opl_pkg::OP_DEL) begin
                if (r_found) fin_cnt = r_count - CW'(1);
                else fin_st = opl_pkg::ST_NOMATCH;
            end
        end
    end

    // memory: one registered read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_WORK && r_left != '0) r_rdata <= r_mem[r_ptr];
        if (r_state == S_WORK && r_pv && r_found) begin
            if (r_op == opl_pkg::OP_INS) r_mem[r_pa + AW'(1)] <= r_rdata;
            else if (r_op == opl_pkg::OP_DEL) r_mem[r_pa - AW'(1)] <= r_rdata;
        end
        if (fin_go && r_err == opl_pkg::ST_OK &&
            (r_op == opl_pkg::OP_INS || r_op == opl_pkg::OP_WR))
            r_mem[r_idx] <= r_pt;
    end

    // control and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // result slot: refilled on finish, freed when taken
            if (fin_go) r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= n_op;
                        r_err   <= n_err;
                        r_ptr   <= n_ptr;
                        r_left  <= n_left;
                        r_any   <= n_any;
                        r_found <= n_found;
                        r_idx   <= idx_e[AW-1:0];
                        r_pt    <= {i_req.point_x, i_req.point_y};
                        r_pv    <= 1'b0;
                        r_state <= (n_err == opl_pkg::ST_OK) ? S_WORK : S_FIN;
                    end
                end
                S_WORK: begin
                    // returning read: first hit captures the point
                    if (r_pv && !r_found && (r_any || r_rdata == r_pt)) begin
                        r_found <= 1'b1;
                        r_old   <= r_rdata;
                    end
                    // next read
                    if (r_left != '0) begin
                        r_pv   <= 1'b1;
                        r_pa   <= r_ptr;
                        r_left <= r_left - CW'(1);
                        r_ptr  <= (r_op == opl_pkg::OP_INS) ? r_ptr - AW'(1)
                                                            : r_ptr + AW'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_os    <= fin_st;
                        r_count <= fin_cnt;
                        r_ocnt  <= CMPW'(fin_cnt) > 0 ? opl_pkg::CNT_W'(CMPW'(fin_cnt))
                                                      : '0;
                        if (fin_st != opl_pkg::ST_OK) r_opt <= '0;
                        else if (r_op == opl_pkg::OP_INS) r_opt <= r_pt;
                        else r_opt <= r_old;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_os;
    assign o_rsp.out_x       = r_opt[DW-1:opl_pkg::COORD_W];
    assign o_rsp.out_y       = r_opt[opl_pkg::COORD_W-1:0];
    assign o_rsp.entry_count = r_ocnt;

endmodule

// ----- sim/ordered_point_list_engine_unit_test.sv -----
`timescale 1ns / 1ps

// Expected results of the point list, in request order
class point_list_scoreboard;
    logic signed [opl_pkg::COORD_W-1:0] px_q[$];
    logic signed [opl_pkg::COORD_W-1:0] py_q[$];
    logic [opl_pkg::STAT_W-1:0]         st_exp[$];
    logic signed [opl_pkg::COORD_W-1:0] ox_exp[$];
    logic signed [opl_pkg::COORD_W-1:0] oy_exp[$];
    logic [opl_pkg::CNT_W-1:0]          cnt_exp[$];
    int unsigned                        mismatches;

    // Predict the result of one accepted request
    function void note_request(logic [opl_pkg::REQ_W-1:0] rq, logic [opl_pkg::POS_W-1:0] pos,
                               logic signed [opl_pkg::COORD_W-1:0] x,
                               logic signed [opl_pkg::COORD_W-1:0] y);
        logic [opl_pkg::STAT_W-1:0]         st;
        logic signed [opl_pkg::COORD_W-1:0] ox, oy;
        int                                 idx, n;
        st = opl_pkg::ST_OK; ox = '0; oy = '0;
        n = px_q.size();
        case (rq)
            opl_pkg::REQ_INS_FIRST, opl_pkg::REQ_INS_LAST, opl_pkg::REQ_INS_AT: begin
                idx = (rq == opl_pkg::REQ_INS_FIRST) ? 0 :
                      (rq == opl_pkg::REQ_INS_LAST) ? n : int'(pos);
                if (n >= opl_pkg::CAPACITY) st = opl_pkg::ST_FULL;
                else if (idx > n) st = opl_pkg::ST_RANGE;
                else begin
                    px_q.insert(idx, x); py_q.insert(idx, y);
                    ox = x; oy = y;
                end
            end
            opl_pkg::REQ_DEL_FIRST, opl_pkg::REQ_DEL_LAST, opl_pkg::REQ_DEL_AT,
            opl_pkg::REQ_DEL_MATCH: begin
                idx = (rq == opl_pkg::REQ_DEL_FIRST) ? 0 :
                      (rq == opl_pkg::REQ_DEL_LAST) ? n - 1 : int'(pos);
                if (rq == opl_pkg::REQ_DEL_MATCH) begin
                    idx = -1;
                    for (int i = n - 1; i >= 0; i--)
                        if (px_q[i] == x && py_q[i] == y) idx = i;
                end
                if (idx < 0 || idx >= n)
                    st = (rq == opl_pkg::REQ_DEL_MATCH) ? opl_pkg::ST_NOMATCH
                                                        : opl_pkg::ST_RANGE;
                else begin
                    ox = px_q[idx]; oy = py_q[idx];
                    px_q.delete(idx); py_q.delete(idx);
                end
            end
            opl_pkg::REQ_GET, opl_pkg::REQ_REPLACE: begin
                if (int'(pos) >= n) st = opl_pkg::ST_RANGE;
                else begin
                    ox = px_q[pos]; oy = py_q[pos];
                    if (rq == opl_pkg::REQ_REPLACE) begin
                        px_q[pos] = x; py_q[pos] = y;
                    end
                end
            end
            default: st = opl_pkg::ST_RANGE;
        endcase
        st_exp.push_back(st); ox_exp.push_back(ox); oy_exp.push_back(oy);
        cnt_exp.push_back(opl_pkg::CNT_W'(px_q.size()));
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [opl_pkg::STAT_W-1:0] st,
                               logic signed [opl_pkg::COORD_W-1:0] ox,
                               logic signed [opl_pkg::COORD_W-1:0] oy,
                               logic [opl_pkg::CNT_W-1:0] cnt);
        if (st_exp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result st=%0d", st);
            return;
        end
        if (st !== st_exp[0] || ox !== ox_exp[0] || oy !== oy_exp[0] ||
            cnt !== cnt_exp[0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp st=%0d x=%0d y=%0d n=%0d got st=%0d x=%0d y=%0d n=%0d",
                         st_exp[0], ox_exp[0], oy_exp[0], cnt_exp[0], st, ox, oy, cnt);
        end
        void'(st_exp.pop_front()); void'(ox_exp.pop_front());
        void'(oy_exp.pop_front()); void'(cnt_exp.pop_front());
    endfunction

    function int pending();
        return st_exp.size();
    endfunction
endclass

module ordered_point_list_engine_unit_test;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   rsp_hold = 0;
    bit   stim_done = 0;

    opl_req_if req_ch();
    opl_rsp_if rsp_ch();
    point_list_scoreboard sb = new();

    ordered_point_list_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0; req_ch.req_type = '0; req_ch.position = '0;
        req_ch.point_x = '0; req_ch.point_y = '0; rsp_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [opl_pkg::COORD_W-1:0] coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // Offer one request and hold it until taken
    task automatic send_req(logic [opl_pkg::REQ_W-1:0] rq, logic [opl_pkg::POS_W-1:0] pos,
                            logic signed [opl_pkg::COORD_W-1:0] x,
                            logic signed [opl_pkg::COORD_W-1:0] y);
        int g;
        g = gap_len();
        repeat (g) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1; req_ch.req_type <= rq; req_ch.position <= pos;
        req_ch.point_x <= x; req_ch.point_y <= y;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(rq, pos, x, y);
    endtask

    // Receiver: random ready, plus one long hold-off
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.entry_count);
        if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= i_rst_n && ($urandom_range(0, 9) < 7);
        end
    end

    // Stimulus
    initial begin
        logic signed [opl_pkg::COORD_W-1:0] mx, my;
        int n, r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // empty list corners and bad codes, then a small list built and torn down
        send_req(opl_pkg::REQ_DEL_FIRST, 0, 0, 0);
        send_req(opl_pkg::REQ_DEL_LAST, 0, 0, 0);
        send_req(opl_pkg::REQ_DEL_MATCH, 0, 0, 0);
        send_req(opl_pkg::REQ_GET, 0, 0, 0);
        send_req(opl_pkg::REQ_REPLACE, 0, 1, 1);
        send_req(opl_pkg::REQ_DEL_AT, 0, 0, 0);
        send_req(opl_pkg::REQ_INS_AT, 1, 5, 5);
        send_req(4'hF, 7'h7F, -1, -1);
        send_req(4'd9, 0, 0, 0);
        send_req(opl_pkg::REQ_INS_FIRST, 0, 32'sh7fffffff, 32'sh80000000);
        send_req(opl_pkg::REQ_INS_LAST, 0, 32'sh80000000, 32'sh7fffffff);
        send_req(opl_pkg::REQ_INS_AT, 2, -1, -1);
        send_req(opl_pkg::REQ_INS_AT, 1, 0, 0);
        send_req(opl_pkg::REQ_INS_AT, 5, 0, 0);
        send_req(opl_pkg::REQ_GET, 3, 0, 0);
        send_req(opl_pkg::REQ_GET, 4, 0, 0);
        send_req(opl_pkg::REQ_REPLACE, 1, 7, 8);
        send_req(opl_pkg::REQ_DEL_MATCH, 0, 7, 8);
        send_req(opl_pkg::REQ_DEL_MATCH, 0, 7, 9);
        send_req(opl_pkg::REQ_DEL_AT, 1, 0, 0);
        send_req(opl_pkg::REQ_DEL_LAST, 0, 0, 0);
        send_req(opl_pkg::REQ_DEL_FIRST, 0, 0, 0);
        // fill to capacity under a long receiver stall
        rsp_hold = 300;
        for (int i = 0; i < opl_pkg::CAPACITY + 2; i++)
            send_req(opl_pkg::REQ_INS_LAST, 7'h7F, i, -i);
        send_req(opl_pkg::REQ_INS_AT, 0, 1, 1);
        send_req(opl_pkg::REQ_GET, 63, 0, 0);
        send_req(opl_pkg::REQ_GET, 64, 0, 0);
        send_req(opl_pkg::REQ_DEL_MATCH, 0, 63, -63);
        // random mix, biased toward drifting between empty and full
        for (int i = 0; i < 1250; i++) begin
            n = sb.px_q.size();
            r = $urandom_range(0, 99);
            if (n > 0 && $urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, n - 1);
                mx = sb.px_q[r]; my = sb.py_q[r];
            end else begin
                mx = coord(); my = coord();
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                send_req(opl_pkg::REQ_W'($urandom_range(9, 15)),
                         opl_pkg::POS_W'($urandom()), mx, my);
            else if ((i / 200) % 2 == 0 ? r < 55 : r < 35)
                send_req(opl_pkg::REQ_W'($urandom_range(0, 2)),
                         opl_pkg::POS_W'($urandom_range(0, 9) == 0 ? $urandom()
                                                                   : $urandom_range(0, n + 1)),
                         mx, my);
            else
                send_req(opl_pkg::REQ_W'($urandom_range(3, 8)),
                         opl_pkg::POS_W'($urandom_range(0, 9) == 0 ? $urandom()
                                                                   : $urandom_range(0, n)),
                         mx, my);
        end
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        stim_done = 1;
        if (sb.mismatches == 0)
            $display("ordered_point_list_engine_unit_test OK");
        else
            $display("ordered_point_list_engine_unit_test NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("ordered_point_list_engine_unit_test NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/opl_pkg.sv
sv/opl_if.sv
sv/ordered_point_list_engine_unit.sv
sim/ordered_point_list_engine_unit_test.sv
